@@ src/hed_pkg.sv @@
// ----------------------------------------------------------------------------
// hed_pkg: shared types and constants of the html entity decoder
// Character codes, store geometry, sequencer states and the delimiter test.
// ----------------------------------------------------------------------------
package hed_pkg;

    // code unit and entity store geometry
    localparam int UNIT_W           = 16;
    localparam int MAX_ENTITY_UNITS = 9;
    localparam int CNT_W            = $clog2(MAX_ENTITY_UNITS + 1);
    localparam int IDX_W            = $clog2(MAX_ENTITY_UNITS);

    // numeric reference accumulator and surrogate split
    localparam int CP_W       = 32;
    localparam int SURR_W     = 20;
    localparam int SURR_SPLIT = 10;
    localparam logic [SURR_W-1:0]                 SURR_BASE   = 20'h10000;
    localparam logic [UNIT_W-SURR_SPLIT-1:0]      SURR_HI_TAG = 6'b110110;
    localparam logic [UNIT_W-SURR_SPLIT-1:0]      SURR_LO_TAG = 6'b110111;

    // character codes
    localparam logic [UNIT_W-1:0] CH_NUL      = 16'h0000;
    localparam logic [UNIT_W-1:0] CH_TAB      = 16'h0009;
    localparam logic [UNIT_W-1:0] CH_CR       = 16'h000D;
    localparam logic [UNIT_W-1:0] CH_SPACE    = 16'h0020;
    localparam logic [UNIT_W-1:0] CH_PRINT_LO = 16'h0021;
    localparam logic [UNIT_W-1:0] CH_PRINT_HI = 16'h007E;
    localparam logic [UNIT_W-1:0] CH_HASH     = 16'h0023;
    localparam logic [UNIT_W-1:0] CH_AMP      = 16'h0026;
    localparam logic [UNIT_W-1:0] CH_SEMI     = 16'h003B;
    localparam logic [UNIT_W-1:0] CH_ZERO     = 16'h0030;
    localparam logic [UNIT_W-1:0] CH_NINE     = 16'h0039;
    localparam logic [UNIT_W-1:0] CH_UP_A     = 16'h0041;
    localparam logic [UNIT_W-1:0] CH_UP_F     = 16'h0046;
    localparam logic [UNIT_W-1:0] CH_UP_X     = 16'h0058;
    localparam logic [UNIT_W-1:0] CH_UP_Z     = 16'h005A;
    localparam logic [UNIT_W-1:0] CH_LOW_A    = 16'h0061;
    localparam logic [UNIT_W-1:0] CH_LOW_F    = 16'h0066;
    localparam logic [UNIT_W-1:0] CH_LOW_M    = 16'h006D;
    localparam logic [UNIT_W-1:0] CH_LOW_P    = 16'h0070;
    localparam logic [UNIT_W-1:0] CH_LOW_X    = 16'h0078;
    localparam logic [UNIT_W-1:0] CH_LOW_Z    = 16'h007A;
    localparam logic [UNIT_W-1:0] CASE_OFFSET = 16'h0020;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROC,
        S_DEC,
        S_DIGIT,
        S_EVAL,
        S_LOW,
        S_FLUSH,
        S_NEXT,
        S_FINISH
    } state_t;

    // accumulator control
    typedef struct packed {
        logic clear;
        logic step;
        logic hex;
    } acc_ctrl_t;

    // entity store write port
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [UNIT_W-1:0] data;
    } store_wr_t;

    // ascii punctuation, whitespace or nul ends an entity
    function automatic logic is_delim(input logic [UNIT_W-1:0] u);
        logic res;
        if (u == CH_NUL) begin
            res = 1'b1;
        end
        else if (u == CH_SPACE || (u >= CH_TAB && u <= CH_CR)) begin
            res = 1'b1;
        end
        else if (u < CH_PRINT_LO || u > CH_PRINT_HI) begin
            res = 1'b0;
        end
        else if ((u >= CH_ZERO && u <= CH_NINE) || (u >= CH_UP_A && u <= CH_UP_Z) ||
                 (u >= CH_LOW_A && u <= CH_LOW_Z)) begin
            res = 1'b0;
        end
        else begin
            res = 1'b1;
        end
        return res;
    endfunction

endpackage

@@ src/hed_store.sv @@
// ----------------------------------------------------------------------------
// hed_store: entity unit store
// Holds the collected entity units; one indexed read plus fixed taps on the
// units that decide the entity kind.
// ----------------------------------------------------------------------------
module hed_store (
    input  logic                        clk,
    input  hed_pkg::store_wr_t          wr,
    input  logic [hed_pkg::IDX_W-1:0]   rd_addr,
    output logic [hed_pkg::UNIT_W-1:0]  rd_data,
    output logic [hed_pkg::UNIT_W-1:0]  unit1,
    output logic [hed_pkg::UNIT_W-1:0]  unit2,
    output logic [hed_pkg::UNIT_W-1:0]  unit3
);
    import hed_pkg::*;

    logic [UNIT_W-1:0] mem_reg [MAX_ENTITY_UNITS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = mem_reg[rd_addr];
    assign unit1   = mem_reg[1];
    assign unit2   = mem_reg[2];
    assign unit3   = mem_reg[3];

endmodule

@@ src/hed_accum.sv @@
// ----------------------------------------------------------------------------
// hed_accum: numeric reference accumulator
// Classifies one digit unit and folds it into the code point, one digit
// per cycle, in base ten or sixteen.
// ----------------------------------------------------------------------------
module hed_accum (
    input  logic                        clk,
    input  hed_pkg::acc_ctrl_t          ctrl,
    input  logic [hed_pkg::UNIT_W-1:0]  unit,
    output logic                        digit_ok,
    output logic [hed_pkg::CP_W-1:0]    cp
);
    import hed_pkg::*;

    logic [CP_W-1:0] cp_reg;
    logic [CP_W-1:0] cp_next;
    logic [3:0]      digit_val;

    always_comb
    begin
        digit_ok  = 1'b0;
        digit_val = 4'd0;
        if (unit >= CH_ZERO && unit <= CH_NINE)
        begin
            digit_ok  = 1'b1;
            digit_val = 4'(unit - CH_ZERO);
        end
        else if (ctrl.hex && unit >= CH_LOW_A && unit <= CH_LOW_F)
        begin
            digit_ok  = 1'b1;
            digit_val = 4'(unit - CH_LOW_A + 16'd10);
        end
        else if (ctrl.hex && unit >= CH_UP_A && unit <= CH_UP_F)
        begin
            digit_ok  = 1'b1;
            digit_val = 4'(unit - CH_UP_A + 16'd10);
        end
    end

    // times sixteen as shift or times ten as shift-add, wrapping at the accumulator width
    always_comb
    begin
        cp_next = cp_reg;
        if (ctrl.clear)
        begin
            cp_next = '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.hex)
            begin
                cp_next = {cp_reg[CP_W-5:0], digit_val};
            end
            else
            begin
                cp_next = {cp_reg[CP_W-4:0], 3'b000} + {cp_reg[CP_W-2:0], 1'b0}
                        + CP_W'(digit_val);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg <= cp_next;
    end

    assign cp = cp_reg;

endmodule

@@ src/html_entity_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// html_entity_decoder_unit: html character reference decoder
// Decodes numeric references and &amp in a utf-16 text stream, with one
// word of lookahead held between input words.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_char / in_last, valid-ready. a zero word or a word with
//   in_last ends the string; each string closes with one terminator word
//   (out_char 0, out_last 1) on the output channel.
//   the decoder takes one input word at a time: in_ready is high only while
//   the sequencer is idle.
//   steps: a word with nothing held passes through the idle, next and finish
//   states, a held word that comes out as plain text also through proc.
//   an entity close adds a decode step, a digit step per digit through the
//   shared accumulator plus one that finds the end of the digits, an
//   evaluate step, a flush step per raw tail word and a closing step.
//   the digit loop and the single store read port make these steps serial.
//   results leave through a one-word output register; while the receiver
//   stalls a step that emits holds and resumes when the register empties,
//   so no word is lost or repeated.
//   reset clears the held word, the entity state and the output valid flag;
//   the entity store itself is not cleared, only counted entries are read.
// ----------------------------------------------------------------------------
module html_entity_decoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hed_pkg::UNIT_W-1:0]  in_char,
    input  logic                        in_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hed_pkg::UNIT_W-1:0]  out_char,
    output logic                        out_last
);
    import hed_pkg::*;

    state_t state_reg, state_next;

    // current input word
    logic [UNIT_W-1:0] c_reg, c_next;
    logic              last_reg, last_next;

    // lookahead and entity state
    logic [UNIT_W-1:0] held_reg, held_next;
    logic              held_valid_reg, held_valid_next;
    logic              inside_reg, inside_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // sequencer scratch
    logic              second_reg, second_next;   // working on the current word
    logic              dropped_reg, dropped_next; // current word was a dropped ';'
    logic              dec_reg, dec_next;         // entity decoded
    logic              hex_reg, hex_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    // output register
    logic [UNIT_W-1:0] out_char_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic              emit_req;
    logic [UNIT_W-1:0] emit_char;
    logic              emit_last;
    logic              slot_free;
    logic              advance;

    store_wr_t         store_wr;
    store_wr_t         store_wr_gated;
    acc_ctrl_t         acc_ctrl;
    acc_ctrl_t         acc_ctrl_gated;
    logic [UNIT_W-1:0] rd_data;
    logic [UNIT_W-1:0] unit1, unit2, unit3;
    logic              digit_ok;
    logic [CP_W-1:0]   cp;

    logic [UNIT_W-1:0] ch_unit;
    logic [UNIT_W-1:0] nx_unit;
    logic [CNT_W-1:0]  cnt_inc;
    logic              nx_delim;
    logic              is_num;
    logic              is_hex;
    logic              is_amp;
    logic              digit_go;
    logic              cp_nonzero;
    logic              cp_wide;
    logic [SURR_W-1:0] surr_v;
    logic              run_cur;
    logic              flush_more;
    state_t            call_done;

    function automatic logic [UNIT_W-1:0] fold_case(input logic [UNIT_W-1:0] u);
        logic [UNIT_W-1:0] res;
        res = u;
        if (u >= CH_UP_A && u <= CH_UP_Z)
        begin
            res = u + CASE_OFFSET;
        end
        return res;
    endfunction

    hed_store u_store (
        .clk     (clk),
        .wr      (store_wr_gated),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .unit1   (unit1),
        .unit2   (unit2),
        .unit3   (unit3)
    );

    hed_accum u_accum (
        .clk      (clk),
        .ctrl     (acc_ctrl_gated),
        .unit     (rd_data),
        .digit_ok (digit_ok),
        .cp       (cp)
    );

    // first pass works on the held word with the new word as lookahead,
    // second pass on a final word with end of text as lookahead
    assign ch_unit    = second_reg ? c_reg : held_reg;
    assign nx_unit    = second_reg ? CH_NUL : c_reg;
    assign cnt_inc    = count_reg + CNT_W'(1);
    assign nx_delim   = is_delim(nx_unit);
    assign is_num     = (count_reg >= CNT_W'(2)) && (unit1 == CH_HASH);
    assign is_hex     = (count_reg >= CNT_W'(3)) && (unit2 == CH_LOW_X || unit2 == CH_UP_X);
    assign is_amp     = (count_reg == CNT_W'(4)) && (fold_case(unit1) == CH_LOW_A)
                     && (fold_case(unit2) == CH_LOW_M) && (fold_case(unit3) == CH_LOW_P);
    assign digit_go   = (idx_reg < count_reg) && digit_ok;
    assign cp_nonzero = (cp != '0);
    assign cp_wide    = (cp[CP_W-1:UNIT_W] != '0);
    assign surr_v     = cp[SURR_W-1:0] - SURR_BASE;
    assign run_cur    = (c_reg != CH_NUL) && last_reg && !dropped_reg;
    assign flush_more = (idx_reg < count_reg);
    assign call_done  = second_reg ? S_FINISH : S_NEXT;

    assign slot_free  = !out_valid_reg || out_ready;
    // a step that emits waits for room in the output register
    assign advance    = !(emit_req && !slot_free);

    always_comb
    begin
        store_wr_gated    = store_wr;
        store_wr_gated.we = store_wr.we && advance;
        acc_ctrl_gated       = acc_ctrl;
        acc_ctrl_gated.step  = acc_ctrl.step && advance;
        acc_ctrl_gated.clear = acc_ctrl.clear && advance;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = held_valid_reg ? S_PROC : S_NEXT;
                end
            end
            S_PROC:
            begin
                if (inside_reg)
                begin
                    if (cnt_inc < CNT_W'(MAX_ENTITY_UNITS))
                    begin
                        state_next = nx_delim ? S_DEC : call_done;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    state_next = call_done;
                end
            end
            S_DEC:
            begin
                state_next = is_num ? S_DIGIT : S_FLUSH;
            end
            S_DIGIT:
            begin
                if (!digit_go)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = (cp_nonzero && cp_wide) ? S_LOW : S_FLUSH;
            end
            S_LOW:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!flush_more)
                begin
                    state_next = call_done;
                end
            end
            S_NEXT:
            begin
                state_next = run_cur ? S_PROC : S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        in_ready        = 1'b0;
        emit_req        = 1'b0;
        emit_char       = CH_NUL;
        emit_last       = 1'b0;
        store_wr.we     = 1'b0;
        store_wr.addr   = count_reg[IDX_W-1:0];
        store_wr.data   = ch_unit;
        acc_ctrl.clear  = 1'b0;
        acc_ctrl.step   = 1'b0;
        acc_ctrl.hex    = hex_reg;
        c_next          = c_reg;
        last_next       = last_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        inside_next     = inside_reg;
        count_next      = count_reg;
        second_next     = second_reg;
        dropped_next    = dropped_reg;
        dec_next        = dec_reg;
        hex_next        = hex_reg;
        idx_next        = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    c_next       = in_char;
                    last_next    = in_last;
                    second_next  = 1'b0;
                    dropped_next = 1'b0;
                end
            end
            S_PROC:
            begin
                if (inside_reg)
                begin
                    store_wr.we = 1'b1;
                    count_next  = cnt_inc;
                    if (!(cnt_inc < CNT_W'(MAX_ENTITY_UNITS)))
                    begin
                        // overlong entity goes out raw
                        idx_next = '0;
                        dec_next = 1'b0;
                    end
                end
                else if (ch_unit == CH_AMP && nx_unit != CH_NUL)
                begin
                    store_wr.we   = 1'b1;
                    store_wr.addr = '0;
                    count_next    = CNT_W'(1);
                    inside_next   = 1'b1;
                end
                else
                begin
                    emit_req  = 1'b1;
                    emit_char = ch_unit;
                end
            end
            S_DEC:
            begin
                acc_ctrl.clear = 1'b1;
                if (is_num)
                begin
                    hex_next = is_hex;
                    idx_next = is_hex ? CNT_W'(3) : CNT_W'(2);
                end
                else if (is_amp)
                begin
                    emit_req  = 1'b1;
                    emit_char = CH_AMP;
                    dec_next  = 1'b1;
                    idx_next  = count_reg;
                end
                else
                begin
                    dec_next = 1'b0;
                    idx_next = '0;
                end
            end
            S_DIGIT:
            begin
                if (digit_go)
                begin
                    acc_ctrl.step = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end
            S_EVAL:
            begin
                if (cp_nonzero)
                begin
                    emit_req  = 1'b1;
                    emit_char = cp_wide ? {SURR_HI_TAG, surr_v[SURR_W-1:SURR_SPLIT]}
                                        : cp[UNIT_W-1:0];
                    dec_next  = 1'b1;
                end
                else
                begin
                    // zero value falls back to raw text
                    dec_next = 1'b0;
                    idx_next = '0;
                end
            end
            S_LOW:
            begin
                emit_req  = 1'b1;
                emit_char = {SURR_LO_TAG, surr_v[SURR_SPLIT-1:0]};
            end
            S_FLUSH:
            begin
                if (flush_more)
                begin
                    emit_req  = 1'b1;
                    emit_char = rd_data;
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else
                begin
                    inside_next  = 1'b0;
                    count_next   = '0;
                    dropped_next = dec_reg && (nx_unit == CH_SEMI);
                end
            end
            S_NEXT:
            begin
                if (run_cur)
                begin
                    second_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (c_reg == CH_NUL || last_reg)
                begin
                    emit_req        = 1'b1;
                    emit_char       = CH_NUL;
                    emit_last       = 1'b1;
                    held_next       = CH_NUL;
                    held_valid_next = 1'b0;
                    inside_next     = 1'b0;
                    count_next      = '0;
                end
                else
                begin
                    held_next       = c_reg;
                    held_valid_next = !dropped_reg;
                end
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_reg       <= CH_NUL;
            held_valid_reg <= 1'b0;
            inside_reg     <= 1'b0;
            count_reg      <= '0;
            second_reg     <= 1'b0;
            dropped_reg    <= 1'b0;
            dec_reg        <= 1'b0;
            hex_reg        <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg      <= state_next;
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                inside_reg     <= inside_next;
                count_reg      <= count_next;
                second_reg     <= second_next;
                dropped_reg    <= dropped_next;
                dec_reg        <= dec_next;
                hex_reg        <= hex_next;
                idx_reg        <= idx_next;
            end
            if (emit_req && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg    <= c_next;
            last_reg <= last_next;
        end
        if (emit_req && slot_free)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule
